>>> rtl/srp_pkg.sv
// ----------------------------------------------------------------------------
// srp_pkg
// Shared types and codes of the sample ring packetizer.
// ----------------------------------------------------------------------------
package srp_pkg;

	// command codes on the cmd port
	localparam logic [1:0] CMD_PUSH   = 2'd0;
	localparam logic [1:0] CMD_PACKET = 2'd1;
	localparam logic [1:0] CMD_SELECT = 2'd2;

	// alternate settings of the streaming interface
	localparam logic [7:0] ALT_IDLE   = 8'd0;
	localparam logic [7:0] ALT_STREAM = 8'd1;

	// configuration register indexes
	localparam logic CFG_CONFIGURED = 1'b0;
	localparam logic CFG_MUTE       = 1'b1;

	// job handed from the front end to the back end
	typedef enum logic [1:0] {
		JOB_DATA,
		JOB_SILENT,
		JOB_UNDER,
		JOB_BAD
	} job_kind_t;

	typedef struct packed {
		job_kind_t kind;
		logic      mute;
	} job_ctl_t;

	typedef enum logic {
		BK_IDLE,
		BK_RUN
	} back_state_t;

endpackage

>>> rtl/srp_ram.sv
// ----------------------------------------------------------------------------
// srp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module srp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/srp_queue.sv
// ----------------------------------------------------------------------------
// srp_queue
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module srp_queue #(
	parameter int WIDTH = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/srp_front.sv
// ----------------------------------------------------------------------------
// srp_front
// Front end: holds one command, writes pushed samples into the ring, tracks
// the ring indices and the streaming state, and queues back-end jobs.
// ----------------------------------------------------------------------------
module srp_front #(
	parameter int RING_DEPTH     = 512,
	parameter int PACKET_SAMPLES = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    cmd,
	input  logic signed [15:0]            sample,
	input  logic [7:0]                    alt_value,
	input  logic                          configured,
	input  logic                          mute,
	input  logic                          q_full,
	output logic                          q_push,
	output logic [$clog2(RING_DEPTH)-1:0] q_addr,
	output srp_pkg::job_ctl_t             q_ctl,
	input  logic                          rd_done,
	output logic                          ram_we,
	output logic [$clog2(RING_DEPTH)-1:0] ram_waddr,
	output logic [15:0]                   ram_wdata
);

	localparam int IW = $clog2(RING_DEPTH);
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
	localparam logic [CW-1:0] PKT_C   = CW'(PACKET_SAMPLES);
	localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);

	logic                 hold_v_q;
	logic [1:0]           cmd_q;
	logic signed [15:0]   sample_q;
	logic [7:0]           alt_q;
	logic [IW-1:0]        wr_idx_q;
	logic [IW-1:0]        rd_idx_q;
	logic                 stream_q;
	logic [CW-1:0]        pend_q;

	logic [CW-1:0]        wr_ext;
	logic [CW-1:0]        rd_ext;
	logic [CW-1:0]        avail;
	logic [CW-1:0]        rd_sum;
	logic [CW-1:0]        rd_adv;
	logic [CW-1:0]        oldest;
	logic                 clobber;
	logic [IW-1:0]        wr_inc;
	logic                 sel_bad;
	logic                 go;
	logic                 job_push;
	srp_pkg::job_kind_t   job_kind;
	logic                 do_write;
	logic                 do_adv;
	logic                 do_restart;
	logic                 do_stop;
	logic                 fire;
	logic                 accept;
	logic [CW-1:0]        pend_add;
	logic [CW-1:0]        pend_sub;

	assign wr_ext = {1'b0, wr_idx_q};
	assign rd_ext = {1'b0, rd_idx_q};
	assign avail  = (wr_ext >= rd_ext) ? (wr_ext - rd_ext) : (wr_ext + DEPTH_C - rd_ext);
	assign rd_sum = rd_ext + PKT_C;
	assign rd_adv = (rd_sum >= DEPTH_C) ? (rd_sum - DEPTH_C) : rd_sum;

	// oldest ring entry still owed to the back end
	assign oldest  = (rd_ext >= pend_q) ? (rd_ext - pend_q) : (rd_ext + DEPTH_C - pend_q);
	assign clobber = (pend_q != '0) && (oldest[IW-1:0] == wr_idx_q);
	assign wr_inc  = (wr_idx_q == LAST_IDX) ? '0 : (wr_idx_q + 1'b1);
	assign sel_bad = !configured || (alt_q > srp_pkg::ALT_STREAM);

	always_comb begin
		go         = 1'b1;
		job_push   = 1'b0;
		job_kind   = srp_pkg::JOB_SILENT;
		do_write   = 1'b0;
		do_adv     = 1'b0;
		do_restart = 1'b0;
		do_stop    = 1'b0;
		case (cmd_q)
			srp_pkg::CMD_PUSH: begin
				// hold a push that would overwrite a sample not yet read out
				go       = !configured || !clobber;
				do_write = configured;
			end
			srp_pkg::CMD_PACKET: begin
				if (stream_q) begin
					go       = !q_full;
					job_push = 1'b1;
					if (avail >= PKT_C) begin
						job_kind = srp_pkg::JOB_DATA;
						do_adv   = 1'b1;
					end else begin
						job_kind = srp_pkg::JOB_UNDER;
					end
				end
			end
			srp_pkg::CMD_SELECT: begin
				if (sel_bad) begin
					go       = !q_full;
					job_push = 1'b1;
					job_kind = srp_pkg::JOB_BAD;
				end else if (alt_q == srp_pkg::ALT_STREAM) begin
					// restart only once all pending reads have drained
					go         = !q_full && (pend_q == '0);
					job_push   = 1'b1;
					job_kind   = srp_pkg::JOB_SILENT;
					do_restart = 1'b1;
				end else begin
					do_stop = 1'b1;
				end
			end
			default: begin
				go = 1'b1;
			end
		endcase
	end

	assign fire       = hold_v_q && go;
	assign busy       = hold_v_q && !go;
	assign accept     = start && !busy;
	assign q_push     = fire && job_push;
	assign q_addr     = rd_idx_q;
	assign q_ctl.kind = job_kind;
	assign q_ctl.mute = mute;
	assign ram_we     = fire && do_write;
	assign ram_waddr  = wr_idx_q;
	assign ram_wdata  = sample_q;

	assign pend_add = (fire && do_adv) ? PKT_C : '0;
	assign pend_sub = {{(CW-1){1'b0}}, rd_done};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			stream_q <= 1'b0;
			pend_q   <= '0;
		end else begin
			if (accept) begin
				hold_v_q <= 1'b1;
			end else if (fire) begin
				hold_v_q <= 1'b0;
			end
			pend_q <= pend_q + pend_add - pend_sub;
			if (fire) begin
				if (do_write) begin
					wr_idx_q <= wr_inc;
				end
				if (do_adv) begin
					rd_idx_q <= rd_adv[IW-1:0];
				end
				if (do_restart) begin
					stream_q <= 1'b1;
					wr_idx_q <= '0;
					rd_idx_q <= '0;
				end
				if (do_stop) begin
					stream_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd;
			sample_q <= sample;
			alt_q    <= alt_value;
		end
	end

endmodule

>>> rtl/srp_back.sv
// ----------------------------------------------------------------------------
// srp_back
// Back end: takes one job at a time from the queue and plays it out, one
// result per cycle, reading ring samples through the RAM read port.
// ----------------------------------------------------------------------------
module srp_back #(
	parameter int RING_DEPTH     = 512,
	parameter int PACKET_SAMPLES = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  logic [$clog2(RING_DEPTH)-1:0] q_addr,
	input  srp_pkg::job_ctl_t             q_ctl,
	output logic                          rd_done,
	output logic [$clog2(RING_DEPTH)-1:0] ram_raddr,
	input  logic [15:0]                   ram_rdata,
	output logic                          strobe,
	output logic signed [15:0]            sample_out,
	output logic                          last,
	output logic                          underrun,
	output logic                          bad_alt
);

	localparam int IW   = $clog2(RING_DEPTH);
	localparam int CNTW = (PACKET_SAMPLES > 1) ? $clog2(PACKET_SAMPLES) : 1;
	localparam logic [CNTW-1:0] CNT_LAST = CNTW'(PACKET_SAMPLES - 1);
	localparam logic [IW-1:0]   LAST_IDX = IW'(RING_DEPTH - 1);

	srp_pkg::back_state_t state_q;
	srp_pkg::back_state_t state_d;
	srp_pkg::job_ctl_t    ctl_q;
	logic [IW-1:0]        addr_q;
	logic [CNTW-1:0]      cnt_q;
	logic                 issue;
	logic                 done;
	logic                 strobe_s2;
	logic                 last_s2;
	logic                 under_s2;
	logic                 bad_s2;
	logic                 zero_s2;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			srp_pkg::BK_IDLE: begin
				if (!q_empty) begin
					state_d = srp_pkg::BK_RUN;
				end
			end
			srp_pkg::BK_RUN: begin
				if (done) begin
					state_d = srp_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = srp_pkg::BK_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		q_pop = 1'b0;
		issue = 1'b0;
		done  = 1'b0;
		case (state_q)
			srp_pkg::BK_IDLE: begin
				q_pop = !q_empty;
			end
			srp_pkg::BK_RUN: begin
				issue = 1'b1;
				done  = (ctl_q.kind == srp_pkg::JOB_BAD) || (cnt_q == CNT_LAST);
			end
			default: begin
				q_pop = 1'b0;
			end
		endcase
	end

	assign rd_done   = issue && (ctl_q.kind == srp_pkg::JOB_DATA);
	assign ram_raddr = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= srp_pkg::BK_IDLE;
			strobe_s2 <= 1'b0;
		end else begin
			state_q   <= state_d;
			strobe_s2 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ctl_q  <= q_ctl;
			addr_q <= q_addr;
			cnt_q  <= '0;
		end else if (issue) begin
			addr_q <= (addr_q == LAST_IDX) ? '0 : (addr_q + 1'b1);
			cnt_q  <= cnt_q + 1'b1;
		end
		last_s2  <= (ctl_q.kind != srp_pkg::JOB_BAD) && (cnt_q == CNT_LAST);
		under_s2 <= (ctl_q.kind == srp_pkg::JOB_UNDER);
		bad_s2   <= (ctl_q.kind == srp_pkg::JOB_BAD);
		zero_s2  <= (ctl_q.kind != srp_pkg::JOB_DATA) || ctl_q.mute;
	end

	// read data lands together with the stage-two flags
	assign strobe     = strobe_s2;
	assign last       = last_s2;
	assign underrun   = under_s2;
	assign bad_alt    = bad_s2;
	assign sample_out = zero_s2 ? '0 : ram_rdata;

endmodule

>>> rtl/sample_ring_packetizer.sv
// ----------------------------------------------------------------------------
// sample_ring_packetizer
// Audio sample ring with isochronous packet assembly.
// ----------------------------------------------------------------------------
// A command is taken on a clock edge where start is high and busy is low.
// Results come out on strobe, one per cycle, and must be taken as they come:
// there is no way to hold them off. A push is registered in the front end
// and, if configured, written into the ring. A packet request in streaming
// or a select other than a valid idle select is checked by the front end
// and handed as a job to a two-entry queue; the back end then plays one job
// at a time out of the ring RAM's single read port, PACKET_SAMPLES results
// for a packet (a single result for a rejected select), with an idle state
// between jobs. A job reaches its first result through the command
// register, the job queue, the back end's job registers and the stage-two
// registers. busy rises while the job queue is full and a packet request or
// select that makes a job waits, while a push would overwrite a ring entry a
// packet has yet to read, and while a restart waits for pending reads to end.
// Pushes go on while packets are being played out. The ring RAM needs no
// clearing after reset. Configuration writes take effect on the next edge
// and are meant for idle periods only.
// ----------------------------------------------------------------------------
module sample_ring_packetizer #(
	parameter int RING_DEPTH     = 512,
	parameter int PACKET_SAMPLES = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [0:0]         cfg_index,
	input  logic [0:0]         cfg_data,
	// command side
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] sample,
	input  logic [7:0]         alt_value,
	// result side
	output logic               strobe,
	output logic signed [15:0] sample_out,
	output logic               last,
	output logic               underrun,
	output logic               bad_alt
);

	localparam int IW = $clog2(RING_DEPTH);
	localparam int QW = IW + $bits(srp_pkg::job_ctl_t);

	logic              configured_q;
	logic              mute_q;

	logic              q_full;
	logic              q_empty;
	logic              q_push;
	logic              q_pop;
	logic [IW-1:0]     push_addr;
	srp_pkg::job_ctl_t push_ctl;
	logic [QW-1:0]     head;
	logic [IW-1:0]     head_addr;
	srp_pkg::job_ctl_t head_ctl;
	logic              rd_done;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [15:0]       ram_wdata;
	logic [IW-1:0]     ram_raddr;
	logic [15:0]       ram_rdata;

	// configuration registers: write only, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			configured_q <= 1'b0;
			mute_q       <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index[0])
				srp_pkg::CFG_CONFIGURED: configured_q <= cfg_data[0];
				srp_pkg::CFG_MUTE:       mute_q       <= cfg_data[0];
				default:                 mute_q       <= mute_q;
			endcase
		end
	end

	// front end: classify commands, own the ring indices
	srp_front #(
		.RING_DEPTH     (RING_DEPTH),
		.PACKET_SAMPLES (PACKET_SAMPLES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.sample     (sample),
		.alt_value  (alt_value),
		.configured (configured_q),
		.mute       (mute_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_addr     (push_addr),
		.q_ctl      (push_ctl),
		.rd_done    (rd_done),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata)
	);

	// job queue decouples command intake from packet playout
	srp_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_addr, push_ctl}),
		.pop       (q_pop),
		.pop_data  (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	assign head_addr = head[QW-1 -: IW];
	assign head_ctl  = srp_pkg::job_ctl_t'(head[$bits(srp_pkg::job_ctl_t)-1:0]);

	// sample ring storage
	srp_ram #(
		.WIDTH (16),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// back end: play out one job at a time
	srp_back #(
		.RING_DEPTH     (RING_DEPTH),
		.PACKET_SAMPLES (PACKET_SAMPLES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.q_addr     (head_addr),
		.q_ctl      (head_ctl),
		.rd_done    (rd_done),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata),
		.strobe     (strobe),
		.sample_out (sample_out),
		.last       (last),
		.underrun   (underrun),
		.bad_alt    (bad_alt)
	);

	// an underrun packet is pure silence and never an error result
	a_under_silent: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && underrun |-> (sample_out == '0) && !bad_alt)
		else $error("underrun result carries data or error flag");

	// a rejected select is a lone, silent result
	a_bad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && bad_alt |-> !last && !underrun && (sample_out == '0))
		else $error("error result carries packet fields");

	// a packet, once started, streams without gaps up to its last sample
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last && !bad_alt |=> strobe)
		else $error("gap inside a packet");

endmodule
